// File: hw/rtl/gmr_pkg.sv
// ----------------------------------------------------------------------------
// gmr_pkg: shared types and constants of the Gaussian mixture E-step block
// Field widths, command codes, fixed-point constants and the exp factor table.
// ----------------------------------------------------------------------------
package gmr_pkg;

	// Component table depth and derived index width
	localparam int MAX_COMPONENTS = 4;
	localparam int IDX_W          = $clog2(MAX_COMPONENTS);

	// Transaction field widths
	localparam int CMD_W  = 2;
	localparam int SLOT_W = 2;
	localparam int VAL_W  = 16;
	localparam int RESP_W = 16;
	localparam int LL_W   = 24;
	localparam int TOT_W  = 40;
	localparam int CFG_W  = 3;

	// Datapath widths: sum of Q.30 terms, shared multiplier, log values
	localparam int SUM_W  = 31 + IDX_W;
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int LT_W   = 36;
	localparam int LN_W   = 24;
	localparam int E_W    = $clog2(SUM_W);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SCORE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Reset value of the active component count
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd4;

	// Fixed-point constants (Q.16)
	localparam logic [16:0] LN2_Q16        = 17'd45426;
	localparam logic [16:0] INV_LN2_Q16    = 17'd94548;
	localparam logic [16:0] HALF_LN2PI_Q16 = 17'd60224;
	localparam logic [24:0] Z_CAP          = 25'd16777216;

	// exp factors 2^(-2^-i) in Q.30, built by repeated integer square root
	typedef logic [30:0] pow_tab_t [17];

	function automatic pow_tab_t build_pow_tab();
		pow_tab_t tab;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		tab[0] = 31'(64'd1 << 29);
		for (int i = 1; i < 17; i++) begin
			x = {33'd0, tab[i-1]} << 30;
			r = '0;
			b = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (b > x) begin
					b = b >> 2;
				end
			end
			for (int k = 0; k < 32; k++) begin
				if (b != 0) begin
					if (x >= r + b) begin
						x = x - (r + b);
						r = (r >> 1) + b;
					end else begin
						r = r >> 1;
					end
					b = b >> 2;
				end
			end
			tab[i] = r[30:0];
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

// File: hw/rtl/gmr_in_if.sv
// ----------------------------------------------------------------------------
// gmr_in_if: command channel of the mixture block
// Valid/ready channel that carries load, score and clear transactions.
// ----------------------------------------------------------------------------
interface gmr_in_if import gmr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [SLOT_W-1:0]       component_slot;
	logic signed [VAL_W-1:0] sample_or_mean;
	logic [VAL_W-1:0]        spread;
	logic [VAL_W-1:0]        weight;

	modport source (output valid, cmd, component_slot, sample_or_mean, spread, weight,
		input ready);
	modport sink (input valid, cmd, component_slot, sample_or_mean, spread, weight,
		output ready);
endinterface

// File: hw/rtl/gmr_out_if.sv
// ----------------------------------------------------------------------------
// gmr_out_if: result channel of the mixture block
// Valid/ready channel that carries one responsibility transaction per component.
// ----------------------------------------------------------------------------
interface gmr_out_if import gmr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SLOT_W-1:0]       component_index;
	logic [RESP_W-1:0]       responsibility;
	logic signed [LL_W-1:0]  sample_loglik;
	logic signed [TOT_W-1:0] running_loglik;
	logic                    last_of_sample;

	modport source (output valid, component_index, responsibility, sample_loglik,
		running_loglik, last_of_sample, input ready);
	modport sink (input valid, component_index, responsibility, sample_loglik,
		running_loglik, last_of_sample, output ready);
endinterface

// File: hw/rtl/gaussian_mixture_responsibility_top.sv
// ----------------------------------------------------------------------------
// gaussian_mixture_responsibility_top: univariate Gaussian mixture E-step
//
//  channel | direction | handshake        | carries
//  req     | in        | valid / ready    | load, score or clear transaction
//  rsp     | out       | valid / ready    | one responsibility per component
//  cfg     | in        | cfg_we           | active component count
//
// A score runs a sequencer around one shared 34x34 multiplier and one radix-2
// divider: per weighted component a divide, a square and two normalize-and-log
// passes, then an exp per used component, one log of the sum and a divide per
// used component's result.
// req.ready is low from score acceptance until the last result is taken;
// rsp stalls hold the sequencer. arst_n clears control state and the total.
// ----------------------------------------------------------------------------
module gaussian_mixture_responsibility_top import gmr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	gmr_in_if.sink           req,
	gmr_out_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE, S_COMP, S_ZDIV, S_ZSQ, S_ZHALF,
		S_LG_NORM, S_LG_SQ, S_LG_BIT, S_LG_LN, S_LG_DONE,
		S_EXP_START, S_EXP_T, S_EXP_STEP, S_EXP_RND, S_EXP_END,
		S_LL, S_OUT_START, S_RDIV, S_OUT_SEND
	} state_t;

	typedef enum logic [1:0] {LG_WEIGHT, LG_SPREAD, LG_SUM} lg_sel_t;

	localparam logic [4:0] FB_WEIGHT = 5'd16;
	localparam logic [4:0] FB_SPREAD = 5'd8;
	localparam logic [4:0] FB_SUM    = 5'd30;
	localparam logic signed [LL_W-1:0]  LL_MAX  = {1'b0, {(LL_W-1){1'b1}}};
	localparam logic signed [LL_W-1:0]  LL_MIN  = {1'b1, {(LL_W-1){1'b0}}};
	localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
	localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

	// Component tables
	logic [VAL_W-1:0] mean_q   [MAX_COMPONENTS];
	logic [VAL_W-1:0] spread_q [MAX_COMPONENTS];
	logic [VAL_W-1:0] weight_q [MAX_COMPONENTS];

	// Control and per-sample state
	state_t                  state_q;
	lg_sel_t                 lg_sel_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        last_q;
	logic                    have_q;
	logic [CFG_W-1:0]        active_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [LL_W-1:0]  ll8_q;
	logic signed [LT_W-1:0]  ll_q;
	logic signed [LT_W-1:0]  mx_q;
	logic [SUM_W-1:0]        sum_q;
	logic signed [VAL_W-1:0] sample_q;
	logic [VAL_W-1:0]        sg_q;
	logic [31:0]             half_q;
	logic signed [LN_W-1:0]  ln_w_q;
	logic signed [LT_W-1:0]  lt_q [MAX_COMPONENTS];
	logic                    used_q [MAX_COMPONENTS];
	logic [30:0]             ex_q [MAX_COMPONENTS];

	// Divider, log and exp unit registers
	logic [SUM_W:0]          div_rem_q;
	logic [31:0]             div_num_q;
	logic [31:0]             div_quo_q;
	logic [SUM_W-1:0]        div_den_q;
	logic [5:0]              div_cnt_q;
	logic [SUM_W-1:0]        lg_m_q;
	logic [E_W-1:0]          lg_e_q;
	logic [15:0]             lg_frac_q;
	logic [3:0]              lg_cnt_q;
	logic [4:0]              lg_fb_q;
	logic [30:0]             exp_v_q;
	logic [15:0]             exp_f_q;
	logic [5:0]              exp_n_q;
	logic [4:0]              exp_i_q;
	logic signed [PROD_W-1:0] prod_q;

	// Result register
	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic [RESP_W-1:0]       out_resp_q;
	logic                    out_last_q;

	// Combinational helpers
	logic [IDX_W-1:0]         n_last;
	logic signed [VAL_W:0]    diff;
	logic [VAL_W-1:0]         ad;
	logic [VAL_W-1:0]         w_cur;
	logic [VAL_W-1:0]         sg_cur;
	logic [SUM_W:0]           trial;
	logic                     ge;
	logic [SUM_W:0]           rem_nx;
	logic [31:0]              quo_nx;
	logic [RESP_W-1:0]        resp_nx;
	logic [24:0]              zc;
	logic [31:0]              sq;
	logic signed [6:0]        ediff;
	logic signed [22:0]       l2;
	logic signed [PROD_W-1:0] ln_full;
	logic signed [LN_W-1:0]   ln_val;
	logic signed [LT_W-1:0]   lt_val;
	logic signed [LT_W-1:0]   x_val;
	logic                     x_big;
	logic [39:0]              tsum;
	logic [30:0]              exv;
	logic [SUM_W+15:0]        rnum;
	logic signed [LT_W-1:0]   llr;
	logic signed [LL_W-1:0]   ll8_nx;
	logic signed [TOT_W:0]    tot_sum;
	logic signed [TOT_W-1:0]  tot_nx;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	// Port drive
	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.component_index = SLOT_W'(out_idx_q);
	assign rsp.responsibility  = out_resp_q;
	assign rsp.sample_loglik   = ll8_q;
	assign rsp.running_loglik  = total_q;
	assign rsp.last_of_sample  = out_last_q;

	// Clamp the active count to the table depth
	always_comb begin
		if (active_q == '0) begin
			n_last = '0;
		end else if (32'(active_q) > MAX_COMPONENTS) begin
			n_last = IDX_W'(MAX_COMPONENTS - 1);
		end else begin
			n_last = IDX_W'(active_q - 1'b1);
		end
	end

	// Distance to the current mean and current table entry
	always_comb begin
		w_cur  = weight_q[j_q];
		sg_cur = (spread_q[j_q] == '0) ? VAL_W'(1) : spread_q[j_q];
		diff   = {sample_q[VAL_W-1], sample_q} - $signed({mean_q[j_q][VAL_W-1], mean_q[j_q]});
		ad     = diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
	end

	// Divider step: one quotient bit per cycle
	always_comb begin
		trial   = {div_rem_q[SUM_W-1:0], div_num_q[31]};
		ge      = (trial >= {1'b0, div_den_q});
		rem_nx  = ge ? (trial - {1'b0, div_den_q}) : trial;
		quo_nx  = {div_quo_q[30:0], ge};
		resp_nx = quo_nx[16] ? {RESP_W{1'b1}} : quo_nx[15:0];
		rnum    = (SUM_W+16)'({ex_q[j_q], 16'd0}) + (SUM_W+16)'(sum_q >> 1);
	end

	// Log, lt and exp helpers
	always_comb begin
		zc      = (div_quo_q > 32'(Z_CAP)) ? Z_CAP : div_quo_q[24:0];
		sq      = prod_q[61:30];
		ediff   = $signed({1'b0, lg_e_q}) - $signed({2'b0, lg_fb_q});
		l2      = {ediff, lg_frac_q};
		ln_full = (prod_q + PROD_W'(32768)) >>> 16;
		ln_val  = ln_full[LN_W-1:0];
		lt_val  = LT_W'(ln_w_q) - $signed({{(LT_W-32){1'b0}}, half_q})
			- $signed(LT_W'(HALF_LN2PI_Q16)) - LT_W'(ln_val);
		x_val   = mx_q - lt_q[j_q];
		x_big   = |x_val[LT_W-1:21];
		tsum    = prod_q[39:0] + 40'd32768;
		exv     = (exp_n_q >= 6'd31) ? '0 : (exp_v_q >> exp_n_q);
	end

	// Sample log-likelihood and running total
	always_comb begin
		llr = (ll_q + LT_W'(128)) >>> 8;
		if (!have_q) begin
			ll8_nx = LL_MIN;
		end else if (llr > LT_W'(LL_MAX)) begin
			ll8_nx = LL_MAX;
		end else if (llr < LT_W'(LL_MIN)) begin
			ll8_nx = LL_MIN;
		end else begin
			ll8_nx = llr[LL_W-1:0];
		end
		tot_sum = (TOT_W+1)'(total_q) + (TOT_W+1)'(ll8_nx);
		if (tot_sum > (TOT_W+1)'(TOT_MAX)) begin
			tot_nx = TOT_MAX;
		end else if (tot_sum < (TOT_W+1)'(TOT_MIN)) begin
			tot_nx = TOT_MIN;
		end else begin
			tot_nx = tot_sum[TOT_W-1:0];
		end
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ZSQ: begin
				mul_a = MUL_W'($signed({1'b0, zc}));
				mul_b = MUL_W'($signed({1'b0, zc}));
			end
			S_LG_SQ: begin
				mul_a = MUL_W'($signed({1'b0, lg_m_q[30:0]}));
				mul_b = MUL_W'($signed({1'b0, lg_m_q[30:0]}));
			end
			S_LG_LN: begin
				mul_a = MUL_W'(l2);
				mul_b = MUL_W'($signed({1'b0, LN2_Q16}));
			end
			S_EXP_START: begin
				mul_a = MUL_W'($signed({1'b0, x_val[20:0]}));
				mul_b = MUL_W'($signed({1'b0, INV_LN2_Q16}));
			end
			S_EXP_STEP: begin
				mul_a = MUL_W'($signed({1'b0, exp_v_q}));
				mul_b = MUL_W'($signed({1'b0, POW_TAB[exp_i_q]}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

	// Write component tables on load transactions
	always_ff @(posedge clk) begin
		if (req.valid && req.ready && req.cmd == CMD_LOAD
				&& 32'(req.component_slot) < MAX_COMPONENTS) begin
			mean_q[IDX_W'(req.component_slot)]   <= req.sample_or_mean;
			spread_q[IDX_W'(req.component_slot)] <= req.spread;
			weight_q[IDX_W'(req.component_slot)] <= req.weight;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lg_sel_q    <= LG_WEIGHT;
			j_q         <= '0;
			last_q      <= '0;
			have_q      <= 1'b0;
			active_q    <= ACTIVE_RESET;
			total_q     <= '0;
			ll8_q       <= '0;
			ll_q        <= '0;
			mx_q        <= '0;
			sum_q       <= '0;
			sample_q    <= '0;
			sg_q        <= '0;
			half_q      <= '0;
			ln_w_q      <= '0;
			div_rem_q   <= '0;
			div_num_q   <= '0;
			div_quo_q   <= '0;
			div_den_q   <= '0;
			div_cnt_q   <= '0;
			lg_m_q      <= '0;
			lg_e_q      <= '0;
			lg_frac_q   <= '0;
			lg_cnt_q    <= '0;
			lg_fb_q     <= '0;
			exp_v_q     <= '0;
			exp_f_q     <= '0;
			exp_n_q     <= '0;
			exp_i_q     <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_resp_q  <= '0;
			out_last_q  <= 1'b0;
			for (int k = 0; k < MAX_COMPONENTS; k++) begin
				lt_q[k]   <= '0;
				used_q[k] <= 1'b0;
				ex_q[k]   <= '0;
			end
		end else begin
			// Take configuration writes at any time
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end

			unique case (state_q)
				// Accept a transaction
				S_IDLE: begin
					if (req.valid) begin
						if (req.cmd == CMD_SCORE) begin
							sample_q <= req.sample_or_mean;
							j_q      <= '0;
							last_q   <= n_last;
							have_q   <= 1'b0;
							sum_q    <= '0;
							state_q  <= S_COMP;
						end else if (req.cmd == CMD_CLEAR) begin
							total_q <= '0;
						end
					end
				end

				// Skip zero-weight components, else start z = |y-mu|/s
				S_COMP: begin
					if (w_cur == '0) begin
						used_q[j_q] <= 1'b0;
						if (j_q == last_q) begin
							j_q     <= '0;
							state_q <= have_q ? S_EXP_START : S_LL;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						sg_q      <= sg_cur;
						div_rem_q <= '0;
						div_num_q <= {ad, 16'd0};
						div_quo_q <= '0;
						div_den_q <= SUM_W'(sg_cur);
						div_cnt_q <= 6'd32;
						state_q   <= S_ZDIV;
					end
				end

				S_ZDIV: begin
					div_rem_q <= rem_nx;
					div_num_q <= div_num_q << 1;
					div_quo_q <= quo_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == 6'd1) begin
						state_q <= S_ZSQ;
					end
				end

				// Square the capped z
				S_ZSQ: begin
					state_q <= S_ZHALF;
				end

				// Halve with rounding, then take ln of the weight
				S_ZHALF: begin
					half_q    <= 32'((prod_q[49:0] + 50'd65536) >> 17);
					lg_m_q    <= SUM_W'(w_cur);
					lg_e_q    <= E_W'(SUM_W - 1);
					lg_frac_q <= '0;
					lg_cnt_q  <= '0;
					lg_fb_q   <= FB_WEIGHT;
					lg_sel_q  <= LG_WEIGHT;
					state_q   <= S_LG_NORM;
				end

				// Normalize one bit a cycle, then keep a Q1.30 mantissa
				S_LG_NORM: begin
					if (lg_m_q[SUM_W-1]) begin
						lg_m_q  <= lg_m_q >> (SUM_W - 31);
						state_q <= S_LG_SQ;
					end else begin
						lg_m_q <= lg_m_q << 1;
						lg_e_q <= lg_e_q - 1'b1;
					end
				end

				S_LG_SQ: begin
					state_q <= S_LG_BIT;
				end

				// Extract one fraction bit per squaring
				S_LG_BIT: begin
					if (sq[31]) begin
						lg_m_q <= SUM_W'(sq >> 1);
						lg_frac_q[4'd15 - lg_cnt_q] <= 1'b1;
					end else begin
						lg_m_q <= SUM_W'(sq);
					end
					lg_cnt_q <= lg_cnt_q + 1'b1;
					state_q  <= (lg_cnt_q == 4'd15) ? S_LG_LN : S_LG_SQ;
				end

				// Scale log2 to ln
				S_LG_LN: begin
					state_q <= S_LG_DONE;
				end

				S_LG_DONE: begin
					unique case (lg_sel_q)
						LG_WEIGHT: begin
							ln_w_q    <= ln_val;
							lg_m_q    <= SUM_W'(sg_q);
							lg_e_q    <= E_W'(SUM_W - 1);
							lg_frac_q <= '0;
							lg_cnt_q  <= '0;
							lg_fb_q   <= FB_SPREAD;
							lg_sel_q  <= LG_SPREAD;
							state_q   <= S_LG_NORM;
						end
						LG_SPREAD: begin
							lt_q[j_q]   <= lt_val;
							used_q[j_q] <= 1'b1;
							if (!have_q || lt_val > mx_q) begin
								mx_q <= lt_val;
							end
							have_q <= 1'b1;
							if (j_q == last_q) begin
								j_q     <= '0;
								state_q <= S_EXP_START;
							end else begin
								j_q     <= j_q + 1'b1;
								state_q <= S_COMP;
							end
						end
						LG_SUM: begin
							ll_q    <= mx_q + LT_W'(ln_val);
							state_q <= S_LL;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				// exp(-(mx - lt)): zero for unused or far components
				S_EXP_START: begin
					if (!used_q[j_q] || x_big) begin
						ex_q[j_q] <= '0;
						if (j_q == last_q) begin
							lg_m_q    <= sum_q;
							lg_e_q    <= E_W'(SUM_W - 1);
							lg_frac_q <= '0;
							lg_cnt_q  <= '0;
							lg_fb_q   <= FB_SUM;
							lg_sel_q  <= LG_SUM;
							state_q   <= S_LG_NORM;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						state_q <= S_EXP_T;
					end
				end

				// Split into integer and fraction of the log2 argument
				S_EXP_T: begin
					exp_n_q <= tsum[37:32];
					exp_f_q <= tsum[31:16];
					exp_v_q <= 31'(64'd1 << 30);
					exp_i_q <= 5'd1;
					state_q <= S_EXP_STEP;
				end

				// Multiply in the factor of each set fraction bit
				S_EXP_STEP: begin
					if (exp_f_q[4'(5'd16 - exp_i_q)]) begin
						state_q <= S_EXP_RND;
					end else if (exp_i_q == 5'd16) begin
						state_q <= S_EXP_END;
					end else begin
						exp_i_q <= exp_i_q + 1'b1;
					end
				end

				S_EXP_RND: begin
					exp_v_q <= 31'((prod_q[61:0] + 62'd536870912) >> 30);
					if (exp_i_q == 5'd16) begin
						state_q <= S_EXP_END;
					end else begin
						exp_i_q <= exp_i_q + 1'b1;
						state_q <= S_EXP_STEP;
					end
				end

				// Store the term and accumulate the sum
				S_EXP_END: begin
					ex_q[j_q] <= exv;
					sum_q     <= sum_q + SUM_W'(exv);
					if (j_q == last_q) begin
						lg_m_q    <= sum_q + SUM_W'(exv);
						lg_e_q    <= E_W'(SUM_W - 1);
						lg_frac_q <= '0;
						lg_cnt_q  <= '0;
						lg_fb_q   <= FB_SUM;
						lg_sel_q  <= LG_SUM;
						state_q   <= S_LG_NORM;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_EXP_START;
					end
				end

				// Round, saturate and accumulate the log-likelihood
				S_LL: begin
					ll8_q   <= ll8_nx;
					total_q <= tot_nx;
					j_q     <= '0;
					state_q <= S_OUT_START;
				end

				// Responsibility = round(ex * 2^16 / sum)
				S_OUT_START: begin
					if (have_q && used_q[j_q]) begin
						div_rem_q <= (SUM_W+1)'(rnum >> 17);
						div_num_q <= {rnum[16:0], 15'd0};
						div_quo_q <= '0;
						div_den_q <= sum_q;
						div_cnt_q <= 6'd17;
						state_q   <= S_RDIV;
					end else begin
						out_resp_q  <= '0;
						out_idx_q   <= j_q;
						out_last_q  <= (j_q == last_q);
						out_valid_q <= 1'b1;
						state_q     <= S_OUT_SEND;
					end
				end

				S_RDIV: begin
					div_rem_q <= rem_nx;
					div_num_q <= div_num_q << 1;
					div_quo_q <= quo_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == 6'd1) begin
						out_resp_q  <= resp_nx;
						out_idx_q   <= j_q;
						out_last_q  <= (j_q == last_q);
						out_valid_q <= 1'b1;
						state_q     <= S_OUT_SEND;
					end
				end

				// Hold the result until taken
				S_OUT_SEND: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						if (j_q == last_q) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_OUT_START;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
